// File: src/canonical_huffman_bit_decoder_defines.svh
// assertion macros for the canonical huffman bit decoder
`ifndef CANONICAL_HUFFMAN_BIT_DECODER_DEFINES_SVH
`define CANONICAL_HUFFMAN_BIT_DECODER_DEFINES_SVH

// condition holds at every edge outside reset
`define CHBD_ASSERT_HOLD(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CHBD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CHBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/chbd_pkg.sv
package chbd_pkg;

   // fixed field widths
   localparam int ACTION_W      = 3;
   localparam int LIDX_W        = 4;
   localparam int COUNT_W       = 8;
   localparam int SYM_W         = 8;
   localparam int ERR_W         = 3;
   localparam int CODE_W        = 16;
   localparam int FIRST_INDEX_W = 9;

   // default sizes
   localparam int DEF_MAX_CODE_LENGTH = 16;
   localparam int DEF_MAX_SYMBOLS     = 256;

   // request actions
   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR  = 3'd0,
      ACT_SET    = 3'd1,
      ACT_APPEND = 3'd2,
      ACT_BUILD  = 3'd3,
      ACT_DECODE = 3'd4
   } action_type;

   // error codes
   typedef enum logic [ERR_W-1:0] {
      ERR_NONE      = 3'd0,
      ERR_NOT_BUILT = 3'd1,
      ERR_BAD_PATH  = 3'd2,
      ERR_TOO_FEW   = 3'd3,
      ERR_UNUSED    = 3'd4,
      ERR_OVERFULL  = 3'd5
   } err_type;

endpackage

// File: src/chbd_ifs.sv
// request channel
interface chbd_req_if;
   import chbd_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [LIDX_W-1:0]   length_index;
   logic [COUNT_W-1:0]  length_count;
   logic [SYM_W-1:0]    symbol_in;
   logic                code_bit;

   modport source (
      output valid, action, length_index, length_count, symbol_in, code_bit,
      input  ready
   );
   modport sink (
      input  valid, action, length_index, length_count, symbol_in, code_bit,
      output ready
   );
endinterface

// response channel
interface chbd_rsp_if;
   import chbd_pkg::*;

   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol_out;
   logic             symbol_valid;
   logic [ERR_W-1:0] error_code;

   modport source (
      output valid, symbol_out, symbol_valid, error_code,
      input  ready
   );
   modport sink (
      input  valid, symbol_out, symbol_valid, error_code,
      output ready
   );
endinterface

// File: src/chbd_ram.sv
module chbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read that holds when not enabled
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/canonical_huffman_bit_decoder.sv
// channel   | dir | handshake          | payload
// req_chan  | in  | valid / ready      | action, length_index, length_count, symbol_in, code_bit
// rsp_chan  | out | valid / ready      | symbol_out, symbol_valid, error_code
//
// clear, set, append, decode and unused actions each give a response, which passes the
// read stage (symbol memory read) and then the output register.
// build walks the table one code length per cycle, then a done state checks the totals
// and loads the result into the read stage; no request is taken meanwhile.
// reset is synchronous; the symbol memory needs no clearing pass.
// a stalled response holds the read stage, and requests stop once both are full.
`include "canonical_huffman_bit_decoder_defines.svh"

module canonical_huffman_bit_decoder #(
   parameter int MAX_CODE_LENGTH = chbd_pkg::DEF_MAX_CODE_LENGTH,
   parameter int MAX_SYMBOLS     = chbd_pkg::DEF_MAX_SYMBOLS
) (
   input logic        clock,
   input logic        reset,
   chbd_req_if.sink   req_chan,
   chbd_rsp_if.source rsp_chan
);
   import chbd_pkg::*;

   localparam int KW   = $clog2(MAX_CODE_LENGTH);
   localparam int PLW  = $clog2(MAX_CODE_LENGTH + 1);
   localparam int AW   = $clog2(MAX_SYMBOLS);
   localparam int SLW  = $clog2(MAX_SYMBOLS + 1);
   localparam int SUMW = $clog2(MAX_CODE_LENGTH * ((1 << COUNT_W) - 1) + 1);
   localparam int CMPW = (SUMW > SLW) ? SUMW : SLW;
   localparam int CW   = CODE_W + 1;
   localparam int IDXW = FIRST_INDEX_W + 1;

   localparam logic [PLW-1:0]  MAX_LEN_P   = PLW'(MAX_CODE_LENGTH);
   localparam logic [KW-1:0]   LAST_K      = KW'(MAX_CODE_LENGTH - 1);
   localparam logic [SLW-1:0]  MAX_SYM_L   = SLW'(MAX_SYMBOLS);
   localparam logic [IDXW-1:0] MAX_SYM_IDX = IDXW'(MAX_SYMBOLS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUILD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic    valid;
      logic    hit;
      logic    from_ram;
      err_type err;
   } stage_type;

   // table and decoder state
   state_type                  state_ff, state_in;
   logic [COUNT_W-1:0]         counts_ff [MAX_CODE_LENGTH];
   logic [COUNT_W-1:0]         counts_in [MAX_CODE_LENGTH];
   logic [CODE_W-1:0]          first_code_ff [MAX_CODE_LENGTH];
   logic [CODE_W-1:0]          first_code_in [MAX_CODE_LENGTH];
   logic [FIRST_INDEX_W-1:0]   first_index_ff [MAX_CODE_LENGTH];
   logic [FIRST_INDEX_W-1:0]   first_index_in [MAX_CODE_LENGTH];
   logic [SLW-1:0]             loaded_ff, loaded_in;
   logic [CODE_W-1:0]          last_code_ff, last_code_in;
   logic [PLW-1:0]             longest_ff, longest_in;
   logic                       built_ff, built_in;
   logic [CODE_W-1:0]          pcode_ff, pcode_in;
   logic [PLW-1:0]             plen_ff, plen_in;

   // build walk
   logic [KW-1:0]              bld_idx_ff, bld_idx_in;
   logic [CW-1:0]              bld_code_ff, bld_code_in;
   logic [SUMW-1:0]            bld_placed_ff, bld_placed_in;
   logic [SUMW-1:0]            bld_total_ff, bld_total_in;
   logic [PLW-1:0]             bld_longest_ff, bld_longest_in;
   logic [CODE_W-1:0]          bld_last_ff, bld_last_in;

   // read stage and output register
   stage_type                  s1_ff, s1_in;
   logic                       out_valid_ff, out_valid_in;
   logic [SYM_W-1:0]           out_symbol_ff, out_symbol_in;
   logic                       out_hit_ff, out_hit_in;
   err_type                    out_err_ff, out_err_in;

   // handshake
   action_type act;
   logic       s1_adv;
   logic       req_fire;
   logic       bld_load;

   // decode datapath
   logic [KW-1:0]        dk;
   logic [CODE_W-1:0]    npc;
   logic [CODE_W-1:0]    dfc;
   logic [COUNT_W-1:0]   dcnt;
   logic [CW-1:0]        ddiff;
   logic                 dhit;
   logic [IDXW-1:0]      didx;
   logic                 din_range;
   logic                 ddead;
   logic [PLW-1:0]       dshift;

   // build datapath
   logic [PLW-1:0]       blen;
   logic [CW-1:0]        bavail;
   logic [COUNT_W-1:0]   bwant;
   logic [COUNT_W-1:0]   btake;
   logic [CMPW-1:0]      bplaced_x;
   logic [CMPW-1:0]      btotal_x;
   logic [CMPW-1:0]      bloaded_x;
   err_type              bld_err;

   // symbol memory ports
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic                 ram_re;
   logic [AW-1:0]        ram_raddr;
   logic [SYM_W-1:0]     ram_rdata;

   // handshake
   assign act      = action_type'(req_chan.action);
   assign s1_adv   = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && (!s1_ff.valid || s1_adv);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign bld_load = (state_ff == ST_DONE) && (!s1_ff.valid || s1_adv);

   // code length lookup for the next bit
   assign dk    = (plen_ff < MAX_LEN_P) ? plen_ff[KW-1:0] : '0;
   assign npc   = {pcode_ff[CODE_W-2:0], req_chan.code_bit};
   assign dfc   = first_code_ff[dk];
   assign dcnt  = counts_ff[dk];
   assign ddiff = {1'b0, npc} - {1'b0, dfc};
   assign dhit  = (dcnt != '0) && (npc >= dfc) && (ddiff < CW'(dcnt));
   assign didx  = IDXW'(first_index_ff[dk]) + IDXW'(ddiff[COUNT_W-1:0]);
   assign din_range = didx < MAX_SYM_IDX;

   // dead prefix: nothing longer can still match
   assign dshift = longest_ff - plen_ff;
   assign ddead  = (plen_ff >= longest_ff) || (pcode_ff > (last_code_ff >> dshift));

   // one canonical length per build cycle
   assign blen   = PLW'(bld_idx_ff) + PLW'(1);
   assign bavail = (CW'(1) << blen) - bld_code_ff;
   assign bwant  = counts_ff[bld_idx_ff];
   assign btake  = (CW'(bwant) < bavail) ? bwant : bavail[COUNT_W-1:0];

   // final build checks
   assign bplaced_x = CMPW'(bld_placed_ff);
   assign btotal_x  = CMPW'(bld_total_ff);
   assign bloaded_x = CMPW'(loaded_ff);
   always_comb begin
      if (bplaced_x > bloaded_x) begin
         bld_err = ERR_TOO_FEW;
      end else if (bplaced_x != bloaded_x) begin
         bld_err = ERR_UNUSED;
      end else if (bplaced_x != btotal_x) begin
         bld_err = ERR_OVERFULL;
      end else begin
         bld_err = ERR_NONE;
      end
   end

   // symbol memory access; reads and writes never come from the same request
   assign ram_we    = req_fire && (act == ACT_APPEND) && (loaded_ff < MAX_SYM_L);
   assign ram_waddr = loaded_ff[AW-1:0];
   assign ram_re    = req_fire && (act == ACT_DECODE) && built_ff &&
                      !((plen_ff != '0) && ddead) && dhit && din_range;
   assign ram_raddr = didx[AW-1:0];

   chbd_ram #(
      .WIDTH (SYM_W),
      .DEPTH (MAX_SYMBOLS)
   ) u_symbol_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_chan.symbol_in),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // next state
   always_comb begin
      state_in       = state_ff;
      counts_in      = counts_ff;
      first_code_in  = first_code_ff;
      first_index_in = first_index_ff;
      loaded_in      = loaded_ff;
      last_code_in   = last_code_ff;
      longest_in     = longest_ff;
      built_in       = built_ff;
      pcode_in       = pcode_ff;
      plen_in        = plen_ff;
      bld_idx_in     = bld_idx_ff;
      bld_code_in    = bld_code_ff;
      bld_placed_in  = bld_placed_ff;
      bld_total_in   = bld_total_ff;
      bld_longest_in = bld_longest_ff;
      bld_last_in    = bld_last_ff;
      s1_in          = s1_ff;
      out_valid_in   = out_valid_ff;
      out_symbol_in  = out_symbol_ff;
      out_hit_in     = out_hit_ff;
      out_err_in     = out_err_ff;

      // output register drains or takes the read stage
      if (s1_ff.valid && s1_adv) begin
         out_valid_in  = 1'b1;
         out_symbol_in = s1_ff.from_ram ? ram_rdata : '0;
         out_hit_in    = s1_ff.hit;
         out_err_in    = s1_ff.err;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
      if (s1_adv) begin
         s1_in.valid = 1'b0;
      end

      // accepted request
      if (req_fire) begin
         s1_in = '{valid: 1'b1, hit: 1'b0, from_ram: 1'b0, err: ERR_NONE};
         case (act)
            ACT_CLEAR: begin
               for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
                  counts_in[i] = '0;
               end
               loaded_in = '0;
               built_in  = 1'b0;
               pcode_in  = '0;
               plen_in   = '0;
            end
            ACT_SET: begin
               if (PLW'(req_chan.length_index) < MAX_LEN_P) begin
                  counts_in[KW'(req_chan.length_index)] = req_chan.length_count;
               end
               built_in = 1'b0;
               pcode_in = '0;
               plen_in  = '0;
            end
            ACT_APPEND: begin
               if (loaded_ff < MAX_SYM_L) begin
                  loaded_in = loaded_ff + SLW'(1);
               end
               built_in = 1'b0;
               pcode_in = '0;
               plen_in  = '0;
            end
            ACT_BUILD: begin
               s1_in.valid    = 1'b0;
               state_in       = ST_BUILD;
               built_in       = 1'b0;
               pcode_in       = '0;
               plen_in        = '0;
               bld_idx_in     = '0;
               bld_code_in    = '0;
               bld_placed_in  = '0;
               bld_total_in   = '0;
               bld_longest_in = '0;
               bld_last_in    = '0;
            end
            ACT_DECODE: begin
               if (!built_ff) begin
                  s1_in.err = ERR_NOT_BUILT;
                  pcode_in  = '0;
                  plen_in   = '0;
               end else if ((plen_ff != '0) && ddead) begin
                  s1_in.err = ERR_BAD_PATH;
                  pcode_in  = '0;
                  plen_in   = '0;
               end else if (dhit) begin
                  s1_in.hit      = 1'b1;
                  s1_in.from_ram = din_range;
                  pcode_in       = '0;
                  plen_in        = '0;
               end else begin
                  pcode_in = npc;
                  plen_in  = plen_ff + PLW'(1);
               end
            end
            default: begin
            end
         endcase
      end

      // build sequencer
      case (state_ff)
         ST_BUILD: begin
            first_code_in[bld_idx_ff]  = bld_code_ff[CODE_W-1:0];
            first_index_in[bld_idx_ff] = FIRST_INDEX_W'(bld_placed_ff);
            if (bwant != '0) begin
               bld_longest_in = blen;
               bld_last_in    = bld_code_ff[CODE_W-1:0] + CODE_W'(bwant) - CODE_W'(1);
            end
            bld_total_in  = bld_total_ff + SUMW'(bwant);
            bld_placed_in = bld_placed_ff + SUMW'(btake);
            bld_code_in   = (bld_code_ff + CW'(btake)) << 1;
            if (bld_idx_ff == LAST_K) begin
               state_in = ST_DONE;
            end else begin
               bld_idx_in = bld_idx_ff + KW'(1);
            end
         end
         ST_DONE: begin
            if (bld_load) begin
               s1_in = '{valid: 1'b1, hit: 1'b0, from_ram: 1'b0, err: bld_err};
               state_in = ST_IDLE;
               if (bld_err == ERR_NONE) begin
                  built_in     = 1'b1;
                  longest_in   = bld_longest_ff;
                  last_code_in = bld_last_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // all registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         for (int i = 0; i < MAX_CODE_LENGTH; i++) begin
            counts_ff[i]      <= '0;
            first_code_ff[i]  <= '0;
            first_index_ff[i] <= '0;
         end
         loaded_ff    <= '0;
         last_code_ff <= '0;
         longest_ff   <= '0;
         built_ff     <= 1'b0;
         pcode_ff     <= '0;
         plen_ff      <= '0;
         s1_ff        <= '{valid: 1'b0, hit: 1'b0, from_ram: 1'b0, err: ERR_NONE};
         out_valid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         counts_ff      <= counts_in;
         first_code_ff  <= first_code_in;
         first_index_ff <= first_index_in;
         loaded_ff      <= loaded_in;
         last_code_ff   <= last_code_in;
         longest_ff     <= longest_in;
         built_ff       <= built_in;
         pcode_ff       <= pcode_in;
         plen_ff        <= plen_in;
         s1_ff          <= s1_in;
         out_valid_ff   <= out_valid_in;
      end
      bld_idx_ff     <= bld_idx_in;
      bld_code_ff    <= bld_code_in;
      bld_placed_ff  <= bld_placed_in;
      bld_total_ff   <= bld_total_in;
      bld_longest_ff <= bld_longest_in;
      bld_last_ff    <= bld_last_in;
      out_symbol_ff  <= out_symbol_in;
      out_hit_ff     <= out_hit_in;
      out_err_ff     <= out_err_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.symbol_out   = out_symbol_ff;
   assign rsp_chan.symbol_valid = out_hit_ff;
   assign rsp_chan.error_code   = out_err_ff;

   // checks
   `CHBD_ASSERT_IMP(a_stall_no_read, clock, reset, s1_ff.valid && !s1_adv, !ram_re, "symbol read while read stage is held")
   `CHBD_ASSERT_HOLD(a_plen_bound, clock, reset, plen_ff <= MAX_LEN_P, "partial code longer than longest code")
   `CHBD_ASSERT_IMP(a_hit_no_err, clock, reset, rsp_chan.valid, !(rsp_chan.symbol_valid && rsp_chan.error_code != ERR_NONE), "symbol reported together with an error")
   `CHBD_ASSERT_NEXT(a_fail_unbuilt, clock, reset, bld_load && bld_err != ERR_NONE, !built_ff, "failed build left table usable")

endmodule
